// ----- sv/ios_pkg.sv -----
package ios_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [VALUE_W-1:0]  value;
    } req_item_t;

    typedef struct packed {
        logic               hit;
        logic               full_reject;
        logic [COUNT_W-1:0] count;
    } rsp_item_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } ctrl_cmd_t;

endpackage

// ----- sv/ios_ctrl.sv -----
module ios_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ios_pkg::ctrl_cmd_t cmd
);

    import ios_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       commit_ok;

    // The result register may be reloaded when it is empty or is being
    // emptied by a transfer in this same cycle.
    assign commit_ok = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_COMMIT) && commit_ok);
        cmd.capture = req_valid && req_ready;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.commit  = (state_reg == ST_COMMIT) && commit_ok;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_ok)
                    state_next = cmd.capture ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- sv/ios_datapath.sv -----
module ios_datapath
#(
    parameter int CAPACITY = ios_pkg::DEFAULT_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ios_pkg::ctrl_cmd_t cmd,
    input  ios_pkg::req_item_t req,
    output ios_pkg::rsp_item_t rsp
);

    import ios_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    req_item_t                  req_reg;
    rsp_item_t                  rsp_reg;
    rsp_item_t                  rsp_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [VALUE_W-1:0]         cell_reg [CAPACITY];
    logic [VALUE_W-1:0]         shift_src [CAPACITY];
    logic [CAPACITY-1:0]        match_vec_reg;
    logic [CAPACITY-1:0]        shift_mask;
    logic                       found;
    logic                       has_room;
    logic                       do_append;
    logic                       do_remove;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
    end

    // Only slots below the count take part, so at most one bit is set:
    // members are distinct by construction.
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int i = 0; i < CAPACITY; i++)
                match_vec_reg[i] <= (cell_reg[i] == req_reg.value) && (CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        found      = |match_vec_reg;
        // With a single match, this marks the matching slot and every slot above it.
        shift_mask = ~(match_vec_reg - CAPACITY'(1));
        has_room   = count_reg < CNT_W'(CAPACITY);
        do_append  = 1'b0;
        do_remove  = 1'b0;
        count_next = count_reg;
        rsp_next   = '0;
        case (req_reg.op)
            OP_ADD:
            begin
                if (!found)
                begin
                    if (has_room)
                    begin
                        do_append    = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        rsp_next.hit = 1'b1;
                    end
                    else
                    begin
                        rsp_next.full_reject = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    do_remove    = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                    rsp_next.hit = 1'b1;
                end
            end
            OP_QUERY:
            begin
                rsp_next.hit = found;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.count = COUNT_W'(count_next);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g < CAPACITY - 1)
            begin : g_src
                assign shift_src[g] = cell_reg[g + 1];
            end
            else
            begin : g_last
                assign shift_src[g] = cell_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.commit && do_append && (count_reg == CNT_W'(g)))
                    cell_reg[g] <= req_reg.value;
                else if (cmd.commit && do_remove && shift_mask[g])
                    cell_reg[g] <= shift_src[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// ----- sv/insertion_ordered_set_store_top.sv -----
// Bounded set of distinct 32-bit values kept in insertion order.
// Requests arrive on the req channel (op and value) and each produces
// exactly one response on the rsp channel (hit, full_reject, count);
// both channels move items by a valid/ready transfer.
// A transferred request is compared against every stored cell in the
// lookup state and its response is registered in the commit state, which
// waits until the output register is free or is being emptied.
// Each request passes through the compare stage and then the update stage
// that shifts the cells on a remove. A new request is taken in the update
// cycle of the previous one once that update proceeds, while an earlier
// response may still wait in the output register.
// If the receiver stalls, the finished response is held and the next
// request is parked before its update until rsp_ready returns.
// Reset empties the set, clears rsp_valid and returns the control to idle;
// the cell contents are not cleared and need no clearing pass, as only
// slots below the count are ever read.
module insertion_ordered_set_store_top
#(
    parameter int CAPACITY = ios_pkg::DEFAULT_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ios_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ios_pkg::rsp_item_t rsp
);

    import ios_pkg::*;

    ctrl_cmd_t cmd;

    ios_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    ios_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- dv/tb.sv -----
module tb;
    import ios_pkg::*;

    localparam int STORE_DEPTH  = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1830;
    localparam int POOL_MAX     = 128;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        value;
        logic               typed;
        logic               hit;
        logic               full_reject;
        logic [COUNT_W-1:0] count;
    } dir_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_CHURN
    } traffic_mode_t;

    // Rows marked typed carry a hand-written response; the rest rely on the predictor.
    localparam dir_row_t DIRECTED_ROWS [23] = '{
        '{OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 7'd0},
        '{OP_REMOVE, 32'h0000_0005, 1'b1, 1'b0, 1'b0, 7'd0},
        '{OP_CLEAR,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 7'd0},
        '{OP_ADD,    32'h7fff_ffff, 1'b1, 1'b1, 1'b0, 7'd1},
        '{OP_ADD,    32'h8000_0000, 1'b1, 1'b1, 1'b0, 7'd2},
        '{OP_ADD,    32'hffff_ffff, 1'b1, 1'b1, 1'b0, 7'd3},
        '{OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 7'd4},
        '{OP_ADD,    32'h7fff_ffff, 1'b1, 1'b0, 1'b0, 7'd4},
        '{OP_QUERY,  32'h8000_0000, 1'b1, 1'b1, 1'b0, 7'd4},
        '{OP_QUERY,  32'h7fff_fffe, 1'b1, 1'b0, 1'b0, 7'd4},
        '{OP_ADD,    32'h5555_5555, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_ADD,    32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_REMOVE, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_QUERY,  32'hffff_ffff, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_QUERY,  32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_REMOVE, 32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_ADD,    32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_REMOVE, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_REMOVE, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_QUERY,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 7'd0},
        '{OP_CLEAR,  32'h1234_5678, 1'b1, 1'b0, 1'b0, 7'd0},
        '{OP_QUERY,  32'hffff_ffff, 1'b1, 1'b0, 1'b0, 7'd0},
        '{OP_ADD,    32'hffff_ffff, 1'b1, 1'b1, 1'b0, 7'd1}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    logic [31:0] members [$];
    rsp_item_t   pending_rsp [$];
    logic [31:0] value_pool [POOL_MAX];
    int          pool_size   = 1;
    bit          calm        = 1'b0;
    int          errors      = 0;
    int          checked     = 0;
    int          requests    = 0;
    int          rejects     = 0;
    int          peak_count  = 0;

    insertion_ordered_set_store_top #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // Applies one request to the shadow set and returns the response it should give.
    function automatic rsp_item_t predict_store(req_item_t item);
        rsp_item_t r;
        int        slot;
        r    = '0;
        slot = -1;
        foreach (members[i])
        begin
            if (slot < 0 && members[i] == item.value)
                slot = i;
        end
        case (item.op)
            OP_ADD:
            begin
                if (slot < 0)
                begin
                    if (members.size() < STORE_DEPTH)
                    begin
                        members.push_back(item.value);
                        r.hit = 1'b1;
                    end
                    else
                    begin
                        r.full_reject = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    members.delete(slot);
                    r.hit = 1'b1;
                end
            end
            OP_QUERY:
            begin
                r.hit = (slot >= 0);
            end
            default:
            begin
                members.delete();
            end
        endcase
        r.count = COUNT_W'(members.size());
        return r;
    endfunction

    function automatic logic [31:0] pick_value(bit prefer_member);
        int r;
        r = $urandom_range(0, 99);
        if (prefer_member && members.size() > 0 && r < 55)
            return members[$urandom_range(0, members.size() - 1)];
        if (r < 60)
            return $urandom;
        if (r < 66)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hffff_ffff;
                2: return 32'h7fff_ffff;
                default: return 32'h8000_0000;
            endcase
        end
        return value_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    function automatic req_item_t random_request(traffic_mode_t mode);
        req_item_t item;
        int        r;
        int        add_pct;
        int        remove_pct;
        int        query_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                add_pct = 85; remove_pct = 5;  query_pct = 9;
            end
            MODE_DRAIN:
            begin
                add_pct = 10; remove_pct = 60; query_pct = 29;
            end
            MODE_CHURN:
            begin
                add_pct = 50; remove_pct = 44; query_pct = 5;
            end
            default:
            begin
                add_pct = 40; remove_pct = 30; query_pct = 28;
            end
        endcase
        if (r < add_pct)
            item.op = OP_ADD;
        else if (r < add_pct + remove_pct)
            item.op = OP_REMOVE;
        else if (r < add_pct + remove_pct + query_pct)
            item.op = OP_QUERY;
        else
            item.op = OP_CLEAR;
        // Pool values are drawn often so that adds collide with existing members.
        if (item.op == OP_ADD && $urandom_range(0, 99) < 70)
            item.value = value_pool[$urandom_range(0, pool_size - 1)];
        else
            item.value = pick_value(item.op != OP_ADD);
        return item;
    endfunction

    // Entered at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(req_item_t item, logic typed, rsp_item_t typed_rsp);
        rsp_item_t predicted;
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_store(item);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        requests++;
        if (predicted.full_reject)
            rejects++;
        if (members.size() > peak_count)
            peak_count = members.size();
        @(negedge clk);
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response %h arrived with none outstanding", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                checked++;
                if (rsp.hit !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, rsp.hit);
                    errors++;
                end
                if (rsp.full_reject !== want.full_reject)
                begin
                    $display("%0t: full_reject expected %b actual %b",
                             $time, want.full_reject, rsp.full_reject);
                    errors++;
                end
                if (rsp.count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, rsp.count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("FAIL insertion_ordered_set_store_top");
        $finish;
    end

    initial
    begin : stimulus
        req_item_t     item;
        rsp_item_t     typed_rsp;
        traffic_mode_t mode;
        int            n;
        int            k;
        int            episode_len;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            item.op               = DIRECTED_ROWS[i].op;
            item.value            = DIRECTED_ROWS[i].value;
            typed_rsp.hit         = DIRECTED_ROWS[i].hit;
            typed_rsp.full_reject = DIRECTED_ROWS[i].full_reject;
            typed_rsp.count       = DIRECTED_ROWS[i].count;
            send_request(item, DIRECTED_ROWS[i].typed, typed_rsp);
        end

        // The sender holds off here until the store has answered everything.
        wait_for_responses();
        @(negedge clk);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n == 0)
                mode = MODE_FILL;
            else
                mode = traffic_mode_t'($urandom_range(0, 3));
            episode_len = (n == 0) ? 200 : $urandom_range(30, 160);
            if (mode == MODE_FILL || mode == MODE_CHURN)
                pool_size = $urandom_range(66, POOL_MAX);
            else
                pool_size = $urandom_range(4, 100);
            for (int p = 0; p < pool_size; p++)
                value_pool[p] = $urandom;
            for (k = 0; k < episode_len && n < RANDOM_ITEMS; k++)
            begin
                calm = (n >= 700 && n < 1000);
                if (n == 1200)
                    wait_for_responses();
                send_request(random_request(mode), 1'b0, '0);
                n++;
            end
        end
        calm = 1'b0;

        wait_for_responses();
        repeat (8) @(negedge clk);

        $display("Sent %0d requests through fill, drain, mixed and churn traffic;",
                 requests);
        $display("%0d responses checked.", checked);
        $display("Set reached %0d members and refused %0d adds while full.", peak_count, rejects);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASS insertion_ordered_set_store_top");
        else
            $display("FAIL insertion_ordered_set_store_top");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ios_pkg.sv
sv/ios_ctrl.sv
sv/ios_datapath.sv
sv/insertion_ordered_set_store_top.sv
dv/tb.sv
